FILE: rtl/client_credit_table_defines.svh
// ----------------------------------------------------------------------------
// client_credit_table_defines
// Assertion macros shared by the client credit table RTL.
// ----------------------------------------------------------------------------
`ifndef CLIENT_CREDIT_TABLE_DEFINES_SVH
`define CLIENT_CREDIT_TABLE_DEFINES_SVH

// property checked on every rising clock edge outside of reset
`define CCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising clock edge, reset included
`define CCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// Types and constants shared by the client credit table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

  // default table size
  localparam int DEF_MAX_CLIENTS = 64;

  // field widths
  localparam int ID_W     = 22;
  localparam int CREDIT_W = 32;
  localparam int CFG_W    = 7;

  // reset value of the active client count
  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(64);

  // depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // operation codes of the input transaction
  localparam logic OP_CONNECT = 1'b0;
  localparam logic OP_USAGE   = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    ST_GRANTED    = 3'd0,
    ST_DISCONNECT = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_ACCEPT     = 3'd3,
    ST_REJECT     = 3'd4
  } status_t;

  // classified command kind
  typedef enum logic {
    CMD_CONNECT,
    CMD_USAGE
  } cmd_kind_t;

  // back end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

  // input transaction
  typedef struct packed {
    logic                operation;
    logic [ID_W-1:0]     client_id;
    logic [CREDIT_W-1:0] amount;
  } in_item_t;

  // result transaction
  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     client_id_out;
    logic [CREDIT_W-1:0] credit_left;
  } out_item_t;

  // queued command from front to back
  typedef struct packed {
    cmd_kind_t           kind;
    logic [ID_W-1:0]     client_id;
    logic [CREDIT_W-1:0] amount;
  } cmd_t;

  // queue head handshake between front and back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

`default_nettype wire

FILE: rtl/cct_front.sv
// ----------------------------------------------------------------------------
// cct_front
// Accepts input transactions, classifies the operation and queues the
// resulting commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_front
  import cct_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output q_head_t       head,
  input  wire logic     pop
);

  localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CntW = $clog2(Q_DEPTH + 1);

  cmd_t            q_mem [Q_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            do_pop;
  cmd_t            cmd_in;

  // classify the incoming operation
  always_comb begin
    cmd_in.kind      = (in_item.operation == OP_USAGE) ? CMD_USAGE : CMD_CONNECT;
    cmd_in.client_id = in_item.client_id;
    cmd_in.amount    = in_item.amount;
  end

  assign in_ready   = (count != CntW'(Q_DEPTH));
  assign push       = in_valid && in_ready;
  assign do_pop     = pop && head.valid;
  assign head.valid = (count != '0);
  assign head.cmd   = q_mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Q_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Q_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (!push && do_pop) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cct_back.sv
// ----------------------------------------------------------------------------
// cct_back
// Client slot table: parallel id match and free slot search, credit memory
// read-modify-write, and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "client_credit_table_defines.svh"

module cct_back
  import cct_pkg::*;
#(
  parameter int MAX_CLIENTS = DEF_MAX_CLIENTS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CFG_W-1:0] active_clients,
  input  wire q_head_t          head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_item
);

  localparam int IW   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CmpW = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;

  // slot state
  logic [MAX_CLIENTS-1:0] slot_valid;
  logic [ID_W-1:0]        slot_client [MAX_CLIENTS];
  logic [CREDIT_W-1:0]    credit_mem  [MAX_CLIENTS];

  // sequencer
  bk_state_t state;
  bk_state_t state_next;
  logic      take;
  logic      exec_fire;

  // lookup results
  logic [MAX_CLIENTS-1:0] vis_mask;
  logic [MAX_CLIENTS-1:0] match_vec;
  logic [MAX_CLIENTS-1:0] free_vec;
  logic [IW-1:0]          hit_idx;
  logic [IW-1:0]          free_idx;
  logic                   hit_any;
  logic                   free_any;

  // registered command and lookup
  cmd_t                cur;
  logic                hit_q;
  logic                free_q;
  logic [IW-1:0]       hit_idx_q;
  logic [IW-1:0]       free_idx_q;
  logic [CREDIT_W-1:0] credit_rd;

  // update path
  logic                covered;
  logic [CREDIT_W-1:0] credit_diff;
  logic                mem_we;
  logic [IW-1:0]       mem_wa;
  logic [CREDIT_W-1:0] mem_wd;
  logic                admit_fire;
  logic                drop_fire;
  out_item_t           result;

  // visible slots and per-slot compare
  for (genvar i = 0; i < MAX_CLIENTS; i++) begin : g_slot
    assign vis_mask[i]  = (CmpW'(i) < CmpW'(active_clients));
    assign match_vec[i] = slot_valid[i] && vis_mask[i] &&
                          (slot_client[i] == head.cmd.client_id);
    assign free_vec[i]  = !slot_valid[i] && vis_mask[i];
  end

  // lowest matching and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int k = MAX_CLIENTS - 1; k >= 0; k--) begin
      if (match_vec[k]) begin
        hit_idx = IW'(k);
      end
      if (free_vec[k]) begin
        free_idx = IW'(k);
      end
    end
    hit_any  = |match_vec;
    free_any = |free_vec;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (head.valid) begin
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!out_valid || out_ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    take      = 1'b0;
    exec_fire = 1'b0;
    unique case (state)
      BK_IDLE: take      = head.valid;
      BK_EXEC: exec_fire = !out_valid || out_ready;
      default: begin
        take      = 1'b0;
        exec_fire = 1'b0;
      end
    endcase
  end

  assign pop = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture command, lookup and credit read
  always_ff @(posedge clk) begin
    if (take) begin
      cur        <= head.cmd;
      hit_q      <= hit_any;
      free_q     <= free_any;
      hit_idx_q  <= hit_idx;
      free_idx_q <= free_idx;
      credit_rd  <= credit_mem[hit_idx];
    end
  end

  // result and table update
  always_comb begin
    covered     = (credit_rd >= cur.amount);
    credit_diff = credit_rd - cur.amount;
    mem_we      = 1'b0;
    mem_wa      = hit_idx_q;
    mem_wd      = credit_diff;
    result.client_id_out = cur.client_id;
    result.credit_left   = '0;
    result.status        = ST_REJECT;
    case (cur.kind)
      CMD_CONNECT: begin
        mem_wa = free_idx_q;
        mem_wd = cur.amount;
        if (hit_q) begin
          result.status      = ST_REJECT;
          result.credit_left = credit_rd;
        end else if (free_q) begin
          mem_we             = exec_fire;
          result.status      = ST_ACCEPT;
          result.credit_left = cur.amount;
        end
      end
      CMD_USAGE: begin
        if (!hit_q) begin
          result.status = ST_NOT_FOUND;
        end else if (covered) begin
          mem_we             = exec_fire;
          result.status      = ST_GRANTED;
          result.credit_left = credit_diff;
        end else begin
          result.status = ST_DISCONNECT;
        end
      end
      default: result.status = ST_REJECT;
    endcase
  end

  // admission and disconnect strobes
  assign admit_fire = exec_fire && cur.kind == CMD_CONNECT && !hit_q && free_q;
  assign drop_fire  = exec_fire && cur.kind == CMD_USAGE && hit_q && !covered;

  // credit memory write
  always_ff @(posedge clk) begin
    if (mem_we) begin
      credit_mem[mem_wa] <= mem_wd;
    end
  end

  // client id write on admission
  always_ff @(posedge clk) begin
    if (admit_fire) begin
      slot_client[free_idx_q] <= cur.client_id;
    end
  end

  // valid bits: set on admission, cleared on disconnect
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (admit_fire) begin
      slot_valid[free_idx_q] <= 1'b1;
    end else if (drop_fire) begin
      slot_valid[hit_idx_q] <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_item <= result;
    end
  end

  // checks
  `CCT_ASSERT(a_take_then_exec, take |=> (state == BK_EXEC), "take did not enter exec")
  `CCT_ASSERT(a_admit_sets_valid, admit_fire |=> slot_valid[$past(free_idx_q)], "admit not set")
  `CCT_ASSERT(a_disc_clears_valid, drop_fire |=> !slot_valid[$past(hit_idx_q)], "slot kept")
  `CCT_ASSERT(a_fire_makes_result, exec_fire |=> (out_valid && state == BK_IDLE), "result missing")

endmodule

`default_nettype wire

FILE: rtl/client_credit_table.sv
// ----------------------------------------------------------------------------
// client_credit_table
// Client credit table: admits clients into free slots and deducts usage
// from their credit, one result transaction per input transaction.
// ----------------------------------------------------------------------------
// An input transaction is queued by the front end (two entries) and handled
// by the back end: when BK_IDLE takes it, the id is compared against every
// visible slot in parallel, the lowest matching and lowest free slot are
// picked and the matching slot's credit is read from the credit memory; BK_EXEC
// does the compare and subtract, writes the slot back and loads the result
// register. A new transaction is taken only once the last one has loaded
// its result; a stalled result holds the back end, and the queue keeps
// accepting until it is full. Slot valid bits are flip-flops cleared by
// reset, so the table is usable right after reset with no clearing pass.
// active_clients (reset 64) limits the visible slots to
// min(active_clients, MAX_CLIENTS); write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module client_credit_table
  import cct_pkg::*;
#(
  parameter int MAX_CLIENTS = DEF_MAX_CLIENTS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_item
);

  logic [CFG_W-1:0] active_clients;
  q_head_t          head;
  logic             pop;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_clients <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_clients <= cfg_wdata;
    end
  end

  // front end: accept and classify
  cct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  // back end: table lookup and update
  cct_back #(
    .MAX_CLIENTS (MAX_CLIENTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .active_clients (active_clients),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the client credit table.
// Connect and usage transactions go in through a valid/ready port. A shadow
// copy of the slot table predicts each reply, and every reply is compared
// in order. A directed run covers the corner cases. Random traffic then runs
// over several slot counts and several mixes of sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb;
  import cct_pkg::*;

  localparam int NUM_SLOTS   = DEF_MAX_CLIENTS;
  localparam int NUM_PHASES  = 9;
  localparam int PHASE_ITEMS = 170;
  localparam int POOL_SIZE   = 96;
  localparam int HOLDOFF_LEN = 300;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [ID_W-1:0]     ID_MAX     = '1;
  localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;

  client_credit_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // clock
  always #10 clk = ~clk;

  // shadow copy of the slot table and the slot count
  bit                  shadow_used [NUM_SLOTS];
  logic [ID_W-1:0]     shadow_id   [NUM_SLOTS];
  logic [CREDIT_W-1:0] shadow_cred [NUM_SLOTS];
  int unsigned         shadow_active = 64;

  in_item_t        request_queue    [$];
  out_item_t       expected_replies [$];
  logic [ID_W-1:0] id_pool [POOL_SIZE];

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          holdoff_req    = 0;
  int          holdoff_taken  = 0;
  int          holdoff_left   = 0;
  int unsigned items_accepted = 0;
  int unsigned replies_seen   = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;
  int unsigned status_tally [5];

  // apply one transaction to the shadow table and return the reply it gives
  function automatic out_item_t apply_to_table(in_item_t req);
    out_item_t rsp;
    int        vis;
    int        hit;
    int        free_slot;
    vis       = (shadow_active > NUM_SLOTS) ? NUM_SLOTS : shadow_active;
    hit       = -1;
    free_slot = -1;
    // scan downward so the lowest matching and lowest free slot win
    for (int i = vis - 1; i >= 0; i--) begin
      if (shadow_used[i] && shadow_id[i] == req.client_id) hit = i;
      if (!shadow_used[i]) free_slot = i;
    end
    rsp.client_id_out = req.client_id;
    rsp.credit_left   = '0;
    if (req.operation == OP_CONNECT) begin
      rsp.status = ST_REJECT;
      if (hit >= 0) begin
        rsp.credit_left = shadow_cred[hit];
      end else if (free_slot >= 0) begin
        shadow_used[free_slot] = 1'b1;
        shadow_id[free_slot]   = req.client_id;
        shadow_cred[free_slot] = req.amount;
        rsp.status             = ST_ACCEPT;
        rsp.credit_left        = req.amount;
      end
    end else if (hit < 0) begin
      rsp.status = ST_NOT_FOUND;
    end else if (shadow_cred[hit] >= req.amount) begin
      shadow_cred[hit] -= req.amount;
      rsp.status       = ST_GRANTED;
      rsp.credit_left  = shadow_cred[hit];
    end else begin
      shadow_used[hit] = 1'b0;
      rsp.status       = ST_DISCONNECT;
    end
    return rsp;
  endfunction

  function automatic in_item_t mk_req(logic op, logic [ID_W-1:0] id,
                                      logic [CREDIT_W-1:0] amt);
    in_item_t r;
    r.operation = op;
    r.client_id = id;
    r.amount    = amt;
    return r;
  endfunction

  // mostly ids from a shared pool so lookups hit, with some pure noise
  function automatic in_item_t rand_request();
    logic                op;
    logic [ID_W-1:0]     id;
    logic [CREDIT_W-1:0] amt;
    int                  pick;
    pick = $urandom_range(99);
    if (pick < 8) return mk_req(1'($urandom_range(1)), ID_W'($urandom_range(ID_MAX)),
                                $urandom);
    op   = ($urandom_range(99) < 40) ? OP_CONNECT : OP_USAGE;
    id   = id_pool[$urandom_range(POOL_SIZE - 1)];
    pick = $urandom_range(99);
    if (op == OP_CONNECT) begin
      if (pick < 10) amt = '0;
      else if (pick < 20) amt = CREDIT_MAX;
      else if (pick < 45) amt = $urandom;
      else amt = $urandom_range(5000, 100);
    end else begin
      if (pick < 5) amt = '0;
      else if (pick < 10) amt = CREDIT_MAX;
      else if (pick < 75) amt = $urandom_range(800);
      else amt = $urandom;
    end
    return mk_req(op, id, amt);
  endfunction

  // input driver: predict on acceptance, then offer the next transaction
  always @(posedge clk) begin : driver
    out_item_t rsp;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rsp = apply_to_table(in_item);
        expected_replies.push_back(rsp);
        status_tally[int'(rsp.status)]++;
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= request_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // reply monitor and receiver stall control
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] reply with nothing expected: status %0d id %h credit %h",
                     $time, out_item.status, out_item.client_id_out, out_item.credit_left);
        end else begin
          want = expected_replies.pop_front();
          if (out_item.status !== want.status ||
              out_item.client_id_out !== want.client_id_out ||
              out_item.credit_left !== want.credit_left) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: exp status %0d id %h credit %h, got %0d %h %h",
                       $time, want.status, want.client_id_out, want.credit_left,
                       out_item.status, out_item.client_id_out, out_item.credit_left);
          end
        end
      end
      // long hold-off on request, otherwise random stalls
      if (holdoff_taken != holdoff_req) begin
        holdoff_taken = holdoff_req;
        holdoff_left  = HOLDOFF_LEN;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("client_credit_table test failed");
      $finish;
    end
  end

  // wait until nothing is queued, offered or outstanding
  task automatic wait_idle();
    @(negedge clk);
    while (request_queue.size() > 0 || in_valid || expected_replies.size() > 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write the slot count, only called while the table is idle
  task automatic write_active(input int unsigned count);
    @(posedge clk);
    cfg_we        <= 1'b1;
    cfg_wdata     <= CFG_W'(count);
    shadow_active = count;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned phase_active [NUM_PHASES];
    logic [ID_W-1:0] id_a;
    logic [ID_W-1:0] id_b;
    phase_active = '{64, 127, 3, 40, 64, 17, 1, 0, 64};
    id_pool[0] = '0;
    id_pool[1] = ID_MAX;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom_range(ID_MAX));
    id_a = id_pool[2] ^ 22'h1;
    id_b = id_pool[3] ^ 22'h2;
    if (id_a == id_b || id_a == '0 || id_a == ID_MAX) id_a = 22'h123456;
    if (id_b == id_a || id_b == '0 || id_b == ID_MAX) id_b = 22'h2abcde;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // extremes of id and credit at the reset slot count
    request_queue.push_back(mk_req(OP_USAGE,   '0,     '0));             // unknown id
    request_queue.push_back(mk_req(OP_CONNECT, '0,     '0));             // zero credit
    request_queue.push_back(mk_req(OP_CONNECT, ID_MAX, CREDIT_MAX));
    request_queue.push_back(mk_req(OP_CONNECT, '0,     32'd5));          // duplicate
    request_queue.push_back(mk_req(OP_USAGE,   ID_MAX, 32'd1));
    request_queue.push_back(mk_req(OP_USAGE,   ID_MAX, CREDIT_MAX - 1)); // drains exactly
    request_queue.push_back(mk_req(OP_USAGE,   ID_MAX, 32'd1));          // not covered
    request_queue.push_back(mk_req(OP_USAGE,   ID_MAX, '0));             // already freed
    request_queue.push_back(mk_req(OP_USAGE,   '0,     '0));             // zero of zero
    wait_idle();

    // two slots: fill and overflow
    write_active(2);
    request_queue.push_back(mk_req(OP_CONNECT, id_a, 32'd1000));
    request_queue.push_back(mk_req(OP_CONNECT, id_b, 32'd2000));         // table full
    wait_idle();

    // no visible slot
    write_active(0);
    request_queue.push_back(mk_req(OP_CONNECT, id_b, 32'd2000));
    request_queue.push_back(mk_req(OP_USAGE,   id_a, 32'd1));
    wait_idle();

    // shrunk count hides slot 1, then a second copy of the same id goes in
    write_active(1);
    request_queue.push_back(mk_req(OP_USAGE,   id_a, '0));
    request_queue.push_back(mk_req(OP_USAGE,   '0,   32'd1));
    request_queue.push_back(mk_req(OP_CONNECT, id_a, 32'd50));
    wait_idle();

    // grown again: the lower copy wins
    write_active(2);
    request_queue.push_back(mk_req(OP_USAGE,   id_a, 32'd10));
    request_queue.push_back(mk_req(OP_CONNECT, id_a, 32'd7));
    wait_idle();

    // count above the table size saturates
    write_active(127);
    request_queue.push_back(mk_req(OP_CONNECT, id_b, 32'd300));
    request_queue.push_back(mk_req(OP_USAGE,   id_a, 32'd41));
    request_queue.push_back(mk_req(OP_USAGE,   id_a, 32'd1));
    wait_idle();

    // random phases over slot counts and idle/stall mixes
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_active(phase_active[ph]);
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 55;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 55;
        end
        default: begin
          send_idle_pct  = 38;
          recv_stall_pct = 38;
        end
      endcase
      // receiver holds off while the sender keeps pushing
      if (ph == 4) holdoff_req++;
      for (int n = 0; n < PHASE_ITEMS; n++) request_queue.push_back(rand_request());
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("ran %0d transactions: directed corners, then random traffic at slot counts 0-127",
             items_accepted);
    $display("replies: granted %0d disconnect %0d not found %0d accept %0d reject %0d",
             status_tally[ST_GRANTED], status_tally[ST_DISCONNECT],
             status_tally[ST_NOT_FOUND], status_tally[ST_ACCEPT], status_tally[ST_REJECT]);
    if (expected_replies.size() > 0) begin
      $display("%0d expected replies never arrived", expected_replies.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("client_credit_table test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("client_credit_table test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/cct_pkg.sv
rtl/cct_front.sv
rtl/cct_back.sv
rtl/client_credit_table.sv
tb/tb.sv
